>>> hdl/fbpa_pkg.sv
package fbpa_pkg;

    localparam int ADDR_W        = 32;
    localparam int BSIZE_W       = 17;
    localparam int SIZE_W        = 18;
    localparam int CNT_W         = 11;
    localparam int SPAN_W        = SIZE_W + CNT_W;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int SETTLE_W      = 2;
    localparam int SETTLE_CYCLES = 3;
    localparam int DIV_BITS      = 2;
    localparam int DIV_STEPS     = ADDR_W / DIV_BITS;

    localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(4);
    localparam logic [CNT_W-1:0]   BCOUNT_RESET = CNT_W'(1);
    localparam logic [CNT_W-1:0]   FREE_MAX = {CNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOPOOL  = 2'd1,
        ST_BADADDR = 2'd2,
        ST_EXHAUST = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_ENABLED  = 3'd0,
        CFG_POOL_BASE     = 3'd1,
        CFG_BLOCK_SIZE    = 3'd2,
        CFG_BLOCK_COUNT   = 3'd3,
        CFG_CHECK_RELEASE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              enabled;
        logic              check;
        logic              settling;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] eff_size;
        logic [CNT_W-1:0]  eff_count;
        logic [SPAN_W-1:0] span;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic rem_zero;
    } t_div_sts;

endpackage

>>> hdl/fbpa_req_if.sv
interface fbpa_req_if;
    import fbpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [ADDR_W-1:0]   release_addr;

    modport source (output valid, output op, output release_addr, input ready);
    modport sink   (input valid, input op, input release_addr, output ready);
endinterface

>>> hdl/fbpa_rsp_if.sv
interface fbpa_rsp_if;
    import fbpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block_addr;
    logic [CNT_W-1:0]    free_count;

    modport source (output valid, output status, output block_addr, output free_count,
                    input ready);
    modport sink   (input valid, input status, input block_addr, input free_count,
                    output ready);
endinterface

>>> hdl/fbpa_cfg.sv
module fbpa_cfg #(
    parameter int ALIGN_BYTES = 4,
    parameter int MAX_BLOCKS  = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output fbpa_pkg::t_cfg                 o_cfg
);
    import fbpa_pkg::*;

    localparam int RECIP_SHIFT = SIZE_W;
    localparam int RECIP_W     = SIZE_W + 1;
    localparam int PROD_W      = SIZE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'd1 << RECIP_SHIFT) / ALIGN_BYTES);
    localparam logic [SIZE_W-1:0]  ALIGN    = SIZE_W'(ALIGN_BYTES);
    localparam logic [SIZE_W-1:0]  ALIGN_M1 = SIZE_W'(ALIGN_BYTES - 1);

    logic                r_enabled;
    logic [ADDR_W-1:0]   r_base;
    logic [BSIZE_W-1:0]  r_bsize;
    logic [CNT_W-1:0]    r_bcount;
    logic                r_check;
    logic [SETTLE_W-1:0] r_settle;

    logic [SIZE_W-1:0]   r_round;
    logic [PROD_W-1:0]   r_prod;
    logic [SIZE_W-1:0]   r_size;
    logic [CNT_W-1:0]    r_count;
    logic [SPAN_W-1:0]   r_span;

    logic [BSIZE_W-1:0]  size_min;
    logic [SIZE_W-1:0]   n_round;
    logic [PROD_W-1:0]   n_prod;
    logic [SIZE_W-1:0]   quot0;
    logic [SIZE_W-1:0]   rem0;
    logic [SIZE_W-1:0]   rem_fin;
    logic [SIZE_W-1:0]   n_size;
    logic [CNT_W-1:0]    n_count;
    logic [SPAN_W-1:0]   n_span;

    always_comb begin
        size_min = (r_bsize == '0) ? BSIZE_W'(1) : r_bsize;
        n_round  = SIZE_W'(size_min) + ALIGN_M1;
        n_prod   = PROD_W'(n_round) * PROD_W'(RECIP);
        quot0    = SIZE_W'(r_prod >> RECIP_SHIFT);
        rem0     = r_round - SIZE_W'(quot0 * ALIGN);
        rem_fin  = (rem0 >= ALIGN) ? (rem0 - ALIGN) : rem0;
        n_size   = r_round - rem_fin;
        n_count  = (32'(r_bcount) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : r_bcount;
        n_span   = SPAN_W'(r_size) * SPAN_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        r_round <= n_round;
        r_prod  <= n_prod;
        r_size  <= n_size;
        r_count <= n_count;
        r_span  <= n_span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_base    <= '0;
            r_bsize   <= BSIZE_RESET;
            r_bcount  <= BCOUNT_RESET;
            r_check   <= 1'b1;
            r_settle  <= SETTLE_W'(SETTLE_CYCLES);
        end else begin
            if (r_settle != '0) begin
                r_settle <= r_settle - SETTLE_W'(1);
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_POOL_ENABLED: begin
                        r_enabled <= i_cfg_wdata[0];
                        r_settle  <= SETTLE_W'(SETTLE_CYCLES);
                    end
                    CFG_POOL_BASE: begin
                        r_base   <= i_cfg_wdata[ADDR_W-1:0];
                        r_settle <= SETTLE_W'(SETTLE_CYCLES);
                    end
                    CFG_BLOCK_SIZE: begin
                        r_bsize  <= i_cfg_wdata[BSIZE_W-1:0];
                        r_settle <= SETTLE_W'(SETTLE_CYCLES);
                    end
                    CFG_BLOCK_COUNT: begin
                        r_bcount <= i_cfg_wdata[CNT_W-1:0];
                        r_settle <= SETTLE_W'(SETTLE_CYCLES);
                    end
                    CFG_CHECK_RELEASE: begin
                        r_check  <= i_cfg_wdata[0];
                        r_settle <= SETTLE_W'(SETTLE_CYCLES);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_cfg.enabled   = r_enabled;
    assign o_cfg.check     = r_check;
    assign o_cfg.settling  = (r_settle != '0);
    assign o_cfg.base      = r_base;
    assign o_cfg.eff_size  = r_size;
    assign o_cfg.eff_count = r_count;
    assign o_cfg.span      = r_span;

endmodule

>>> hdl/fbpa_div.sv
module fbpa_div #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [fbpa_pkg::ADDR_W-1:0]      i_dividend,
    input  logic [fbpa_pkg::SIZE_W-1:0]      i_divisor,
    output fbpa_pkg::t_div_sts               o_sts,
    output logic [$clog2(MAX_BLOCKS)-1:0]    o_qmod
);
    import fbpa_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int STEP_W = $clog2(DIV_STEPS + 1);
    localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(MAX_BLOCKS);

    logic [ADDR_W-1:0] r_dvd;
    logic [SIZE_W-1:0] r_rem;
    logic [IDX_W-1:0]  r_qmod;
    logic [STEP_W-1:0] r_cnt;

    logic [ADDR_W-1:0] n_dvd;
    logic [SIZE_W-1:0] n_rem;
    logic [IDX_W-1:0]  n_qmod;
    logic [SIZE_W:0]   trial;
    logic [IDX_W:0]    qacc;
    logic              qbit;

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_qmod = r_qmod;
        trial  = '0;
        qacc   = '0;
        qbit   = 1'b0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {n_rem, n_dvd[ADDR_W-1]};
            n_dvd = {n_dvd[ADDR_W-2:0], 1'b0};
            qbit  = (trial >= {1'b0, i_divisor});
            if (qbit) begin
                trial = trial - {1'b0, i_divisor};
            end
            n_rem = trial[SIZE_W-1:0];
            qacc  = {n_qmod, qbit};
            if (qacc >= MODULUS) begin
                qacc = qacc - MODULUS;
            end
            n_qmod = qacc[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt  <= STEP_W'(DIV_STEPS);
            r_dvd  <= i_dividend;
            r_rem  <= '0;
            r_qmod <= '0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - STEP_W'(1);
            r_dvd  <= n_dvd;
            r_rem  <= n_rem;
            r_qmod <= n_qmod;
        end
    end

    assign o_sts.busy     = (r_cnt != '0);
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_qmod         = r_qmod;

endmodule

>>> hdl/fbpa_link_ram.sv
module fbpa_link_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/fixed_block_pool_allocator.sv
// Accept to result: query or disabled pool go straight to S_DONE; get runs S_MUL and S_ADD,
// a free-list pop reading the link memory in S_POP first; release waits in S_DIV on the
// 16-step radix-4 divider. Throughput: one word at a time; next word accepted the cycle
// after the result registers, unless settling. Reset (synchronous, active low) and any write
// to a defined config register reinitialize the pool; input ready stays low while block
// size and span are recomputed. Link memory is not cleared; only pushed entries are read.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS  = 1024,
    parameter int ALIGN_BYTES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    fbpa_req_if.sink                        i_req,
    fbpa_rsp_if.source                      o_rsp
);
    import fbpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int MUL_W = IDX_W + SIZE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_MUL,
        S_ADD,
        S_DIV,
        S_DONE
    } t_state;

    t_cfg              cfg;
    t_div_sts          div_sts;
    logic [IDX_W-1:0]  div_qmod;

    t_state            r_state;
    logic [IDX_W-1:0]  r_head;
    logic              r_head_valid;
    logic [CNT_W-1:0]  r_next;
    logic [CNT_W-1:0]  r_free;
    logic [IDX_W-1:0]  r_idx;
    logic [MUL_W-1:0]  r_prod;
    logic [ADDR_W-1:0] r_offset;
    t_status           r_res_status;
    logic [ADDR_W-1:0] r_res_addr;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [ADDR_W-1:0] r_out_addr;
    logic [CNT_W-1:0]  r_out_free;

    logic              acc;
    logic [ADDR_W-1:0] offset;
    logic              rel_bad;
    logic              div_start;
    logic              ram_re;
    logic              ram_we;
    logic [IDX_W:0]    ram_wdata;
    logic [IDX_W:0]    ram_rdata;

    assign i_req.ready = (r_state == S_IDLE) && !cfg.settling;
    assign acc         = i_req.valid && i_req.ready;
    assign offset      = i_req.release_addr - cfg.base;
    assign rel_bad     = cfg.check && ((r_offset >= ADDR_W'(cfg.span)) || !div_sts.rem_zero);
    assign div_start   = acc && cfg.enabled && (i_req.op == OP_RELEASE);
    assign ram_re      = acc && cfg.enabled && (i_req.op == OP_GET) && r_head_valid;
    assign ram_we      = (r_state == S_DIV) && !div_sts.busy && !rel_bad;
    assign ram_wdata   = {r_head_valid, r_head};

    fbpa_cfg #(
        .ALIGN_BYTES (ALIGN_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    fbpa_div #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (offset),
        .i_divisor  (cfg.eff_size),
        .o_sts      (div_sts),
        .o_qmod     (div_qmod)
    );

    fbpa_link_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (IDX_W + 1)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (div_qmod),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_next       <= '0;
            r_free       <= '0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_res_status <= ST_OK;
                        r_res_addr   <= '0;
                        r_state      <= S_DONE;
                        if (!cfg.enabled) begin
                            r_res_status <= ST_NOPOOL;
                        end else begin
                            case (i_req.op)
                                OP_GET: begin
                                    if (r_head_valid) begin
                                        r_idx   <= r_head;
                                        r_state <= S_POP;
                                        if (r_free != '0) begin
                                            r_free <= r_free - CNT_W'(1);
                                        end
                                    end else if (r_next < cfg.eff_count) begin
                                        r_idx   <= IDX_W'(32'(r_next));
                                        r_next  <= r_next + CNT_W'(1);
                                        r_state <= S_MUL;
                                        if (r_free != '0) begin
                                            r_free <= r_free - CNT_W'(1);
                                        end
                                    end else begin
                                        r_res_status <= ST_EXHAUST;
                                    end
                                end
                                OP_RELEASE: begin
                                    r_offset <= offset;
                                    r_state  <= S_DIV;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                S_POP: begin
                    r_head       <= ram_rdata[IDX_W-1:0];
                    r_head_valid <= ram_rdata[IDX_W];
                    r_state      <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= MUL_W'(r_idx) * MUL_W'(cfg.eff_size);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_res_addr <= cfg.base + ADDR_W'(r_prod);
                    r_state    <= S_DONE;
                end
                S_DIV: begin
                    if (!div_sts.busy) begin
                        if (rel_bad) begin
                            r_res_status <= ST_BADADDR;
                        end else begin
                            r_head       <= div_qmod;
                            r_head_valid <= 1'b1;
                            if (r_free != FREE_MAX) begin
                                r_free <= r_free + CNT_W'(1);
                            end
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_addr   <= r_res_addr;
                        r_out_free   <= (r_res_status == ST_NOPOOL) ? '0 : r_free;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (cfg.settling) begin
                r_head       <= '0;
                r_head_valid <= 1'b0;
                r_next       <= '0;
                r_free       <= cfg.eff_count;
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.block_addr = r_out_addr;
    assign o_rsp.free_count = r_out_free;

endmodule

>>> tb/fixed_block_pool_allocator_test.sv
module fixed_block_pool_allocator_test;
    import fbpa_pkg::*;

    localparam int POOL_CAP      = 1024;
    localparam int ALIGN         = 4;
    localparam int LINK_W        = $clog2(POOL_CAP);
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 3000;
    localparam int TAIL_CYCLES   = 20;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] release_addr;
    } t_pool_word;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] block_addr;
        logic [CNT_W-1:0]  free_count;
    } t_pool_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_POOL_ENABLED;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  send_valid = 1'b0;
    logic [OP_W-1:0]       send_op = OP_GET;
    logic [ADDR_W-1:0]     send_addr = '0;
    logic                  take_ready = 1'b0;

    fbpa_req_if req_ch ();
    fbpa_rsp_if rsp_ch ();

    assign req_ch.valid        = send_valid;
    assign req_ch.op           = send_op;
    assign req_ch.release_addr = send_addr;
    assign rsp_ch.ready        = take_ready;

    fixed_block_pool_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // pool shadow: configuration and free-list state
    logic                pool_on;
    logic [ADDR_W-1:0]   pool_base_r;
    logic [BSIZE_W-1:0]  size_req;
    logic [CNT_W-1:0]    count_req;
    logic                check_on;
    logic [LINK_W-1:0]   link_next [POOL_CAP];
    logic                link_more [POOL_CAP];
    logic [LINK_W-1:0]   head_idx;
    logic                head_ok;
    logic [CNT_W-1:0]    fresh_idx;
    logic [CNT_W-1:0]    free_now;

    t_pool_word    word_q[$];
    t_pool_outcome awaited_outcomes[$];

    int  fail_count = 0;
    int  send_gap = 0;
    int  sink_wait = 0;
    int  hold_left = 0;
    int  holds_asked = 0;
    int  holds_done = 0;
    int  idle_cycles = 0;
    bit  steady = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [SIZE_W-1:0] rounded_size(input logic [BSIZE_W-1:0] req);
        logic [SIZE_W-1:0] s;
        s = (req == '0) ? SIZE_W'(1) : SIZE_W'(req);
        return ((s + SIZE_W'(ALIGN - 1)) / SIZE_W'(ALIGN)) * SIZE_W'(ALIGN);
    endfunction

    function automatic logic [CNT_W-1:0] usable_count(input logic [CNT_W-1:0] req);
        return (req > CNT_W'(POOL_CAP)) ? CNT_W'(POOL_CAP) : req;
    endfunction

    function automatic logic [ADDR_W-1:0] block_start(input logic [ADDR_W-1:0] base,
                                                      input logic [CNT_W-1:0]  slot,
                                                      input logic [SIZE_W-1:0] sz);
        return base + ADDR_W'(slot) * ADDR_W'(sz);
    endfunction

    function automatic void pool_reinit();
        head_idx  = '0;
        head_ok   = 1'b0;
        fresh_idx = '0;
        free_now  = usable_count(count_req);
    endfunction

    function automatic t_pool_outcome pool_outcome(input logic [OP_W-1:0]   op,
                                                   input logic [ADDR_W-1:0] addr);
        t_pool_outcome     r;
        logic [SIZE_W-1:0] sz;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] quot;
        logic [SPAN_W-1:0] span;
        logic [LINK_W-1:0] slot;
        r.status     = ST_OK;
        r.block_addr = '0;
        r.free_count = '0;
        if (!pool_on) begin
            r.status = ST_NOPOOL;
            return r;
        end
        sz  = rounded_size(size_req);
        cnt = usable_count(count_req);
        case (op)
            OP_GET: begin
                if (head_ok) begin
                    slot         = head_idx;
                    r.block_addr = block_start(pool_base_r, CNT_W'(slot), sz);
                    head_idx     = link_next[slot];
                    head_ok      = link_more[slot];
                    if (free_now != '0) free_now = free_now - CNT_W'(1);
                end else if (fresh_idx < cnt) begin
                    r.block_addr = block_start(pool_base_r, fresh_idx, sz);
                    fresh_idx    = fresh_idx + CNT_W'(1);
                    if (free_now != '0) free_now = free_now - CNT_W'(1);
                end else begin
                    r.status = ST_EXHAUST;
                end
            end
            OP_RELEASE: begin
                offset = addr - pool_base_r;
                span   = SPAN_W'(cnt) * SPAN_W'(sz);
                if (check_on && (offset >= ADDR_W'(span) || offset % ADDR_W'(sz) != '0)) begin
                    r.status = ST_BADADDR;
                end else begin
                    quot            = offset / ADDR_W'(sz);
                    slot            = quot[LINK_W-1:0];
                    link_next[slot] = head_idx;
                    link_more[slot] = head_ok;
                    head_idx        = slot;
                    head_ok         = 1'b1;
                    if (free_now != FREE_MAX) free_now = free_now + CNT_W'(1);
                end
            end
            default: ;
        endcase
        r.free_count = free_now;
        return r;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ADDR_W-1:0] release_target(input logic [ADDR_W-1:0] base,
                                                         input logic [SIZE_W-1:0] sz,
                                                         input logic [CNT_W-1:0]  cnt);
        int unsigned      pick;
        logic [CNT_W-1:0] slot;
        pick = $urandom_range(0, 9);
        slot = (cnt == '0) ? '0 : CNT_W'($urandom_range(0, int'(cnt) - 1));
        if (pick < 6) return block_start(base, slot, sz);
        if (pick == 6)
            return block_start(base, slot, sz)
                   + ADDR_W'($urandom_range(1, (sz > 1) ? int'(sz) - 1 : 1));
        if (pick == 7) return block_start(base, cnt + CNT_W'($urandom_range(0, 3)), sz);
        if (pick == 8) return base - ADDR_W'($urandom_range(1, 64));
        return $urandom;
    endfunction

    task automatic add_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        t_pool_word w;
        w.op           = op;
        w.release_addr = addr;
        word_q.push_back(w);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (word_q.size() != 0 || send_valid || awaited_outcomes.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_POOL_ENABLED: pool_on     = value[0];
            CFG_POOL_BASE:    pool_base_r = value;
            CFG_BLOCK_SIZE:   size_req    = value[BSIZE_W-1:0];
            CFG_BLOCK_COUNT:  count_req   = value[CNT_W-1:0];
            default:          check_on    = value[0];
        endcase
        pool_reinit();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_pool(input logic en, input logic [ADDR_W-1:0] base,
                            input logic [BSIZE_W-1:0] size, input logic [CNT_W-1:0] count,
                            input logic chk);
        write_reg(CFG_POOL_ENABLED, CFG_DATA_W'(en));
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(size));
        write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_CHECK_RELEASE, CFG_DATA_W'(chk));
    endtask

    task automatic random_phase(input logic en, input logic [ADDR_W-1:0] base,
                                input logic [BSIZE_W-1:0] size, input logic [CNT_W-1:0] count,
                                input logic chk, input int n, input bit squeeze);
        logic [SIZE_W-1:0] sz;
        logic [CNT_W-1:0]  cnt;
        int unsigned       r;
        set_pool(en, base, size, count, chk);
        sz  = rounded_size(size);
        cnt = usable_count(count);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 45)      add_word(OP_GET, $urandom);
            else if (r < 85) add_word(OP_RELEASE, release_target(base, sz, cnt));
            else if (r < 95) add_word(OP_QUERY, $urandom);
            else             add_word(OP_SPARE, $urandom);
        end
        if (squeeze) holds_asked++;
        drain();
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_req
        t_pool_word w;
        if (!i_rst_n) begin
            send_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                awaited_outcomes.push_back(pool_outcome(req_ch.op, req_ch.release_addr));
            if (!send_valid || req_ch.ready) begin
                if (send_gap != 0) begin
                    send_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end else if (word_q.size() != 0) begin
                    w          = word_q.pop_front();
                    send_valid <= 1'b1;
                    send_op    <= w.op;
                    send_addr  <= w.release_addr;
                    send_gap   <= steady ? 0 : pick_gap();
                end else begin
                    send_valid <= 1'b0;
                end
            end
        end
    end

    // result ready, with random stalls and the long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            take_ready <= 1'b0;
            sink_wait  <= 0;
        end else if (hold_left != 0) begin
            take_ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            take_ready <= 1'b0;
            holds_done <= holds_asked;
            hold_left  <= HOLD_CYCLES;
        end else if (sink_wait != 0) begin
            take_ready <= 1'b0;
            sink_wait  <= sink_wait - 1;
        end else begin
            take_ready <= 1'b1;
            sink_wait  <= steady ? 0 : pick_gap();
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch_rsp
        t_pool_outcome want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_outcomes.size() == 0) begin
                $error("result word with nothing outstanding");
                fail_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status,
                           rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.block_addr !== want.block_addr) begin
                    $error("block_addr mismatch: expected %08h, got %08h", want.block_addr,
                           rsp_ch.block_addr);
                    fail_count++;
                end
                if (rsp_ch.free_count !== want.free_count) begin
                    $error("free_count mismatch: expected %0d, got %0d", want.free_count,
                           rsp_ch.free_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        pool_on     = 1'b0;
        pool_base_r = '0;
        size_req    = BSIZE_RESET;
        count_req   = BCOUNT_RESET;
        check_on    = 1'b1;
        pool_reinit();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled after reset
        add_word(OP_GET, 32'h0);
        add_word(OP_RELEASE, 32'h0);
        add_word(OP_QUERY, 32'hFFFF_FFFF);
        add_word(OP_SPARE, 32'h0);
        drain();

        // enable only: reset base, size and count
        write_reg(CFG_POOL_ENABLED, 32'h1);
        add_word(OP_GET, 32'h0);
        add_word(OP_GET, 32'h0);
        add_word(OP_RELEASE, 32'h4);
        add_word(OP_RELEASE, 32'h0);
        add_word(OP_GET, 32'h0);
        drain();

        // three blocks of five bytes, rounded to eight
        set_pool(1'b1, 32'h0000_1000, 17'd5, 11'd3, 1'b1);
        repeat (4) add_word(OP_GET, 32'h0);
        add_word(OP_RELEASE, 32'h0000_1008);
        add_word(OP_RELEASE, 32'h0000_100C);
        add_word(OP_RELEASE, 32'h0000_1018);
        add_word(OP_RELEASE, 32'h0000_0FF8);
        add_word(OP_GET, 32'h0);
        add_word(OP_QUERY, 32'h0);
        drain();

        // empty pool near the top of the address space, zero size
        set_pool(1'b1, 32'hFFFF_FFF0, 17'd0, 11'd0, 1'b1);
        add_word(OP_GET, 32'h0);
        add_word(OP_RELEASE, 32'hFFFF_FFF0);
        drain();
        write_reg(CFG_CHECK_RELEASE, 32'h0);
        add_word(OP_RELEASE, 32'h0000_0005);
        add_word(OP_GET, 32'h0);
        add_word(OP_SPARE, 32'h0);
        drain();

        random_phase(1'b1, $urandom, 17'd16, 11'd8, 1'b1, 100, 1'b0);
        random_phase(1'b1, 32'hFFFF_FF00, 17'd65536, 11'd1024, 1'b1, 80, 1'b0);
        steady = 1'b1;
        random_phase(1'b1, 32'h0, 17'd1, 11'd2047, 1'b0, 80, 1'b0);
        steady = 1'b0;
        random_phase(1'b1, 32'hFFFF_FFFF, 17'h1FFFF, 11'd1024, 1'b1, 40, 1'b0);
        repeat (4)
            random_phase(1'b1, $urandom,
                         ($urandom_range(0, 3) == 0) ? BSIZE_W'($urandom_range(0, 131071))
                                                     : BSIZE_W'($urandom_range(1, 64)),
                         CNT_W'($urandom_range(1, 12)), 1'($urandom_range(0, 1)), 45, 1'b0);
        random_phase(1'b0, $urandom, BSIZE_W'($urandom_range(1, 64)), 11'd4, 1'b1, 20, 1'b0);
        random_phase(1'b1, $urandom, 17'd3, 11'd6, 1'b1, 50, 1'b1);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
